@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Item kinds
  localparam logic [1:0] KIND_PUT_CURSOR = 2'd0;
  localparam logic [1:0] KIND_PUT_AT     = 2'd1;
  localparam logic [1:0] KIND_CLEAR      = 2'd2;
  localparam logic [1:0] KIND_READ       = 2'd3;

  // Control characters
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  // Register indexes
  localparam logic [1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [1:0] CFG_TAB_WIDTH   = 2'd1;

  // Reset values of the registers
  localparam logic [5:0] ROWS_IN_USE_RST = 6'd32;
  localparam logic [6:0] TAB_WIDTH_RST   = 7'd4;

  // Sweep modes
  localparam logic [1:0] SWP_RESET  = 2'd0;
  localparam logic [1:0] SWP_CLEAR  = 2'd1;
  localparam logic [1:0] SWP_SCROLL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;      // latch the input beat
    logic       exec;        // perform the item's action and cursor update
    logic       sweep_init;  // load sweep counter and bounds
    logic [1:0] sweep_mode;
    logic       sweep_run;   // issue one sweep step
    logic       sweep_done;  // finish sweep: fix cursor, flag scroll
    logic       cap_cell;    // capture read data
    logic       load_out;    // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       scroll_need;
    logic       sweep_last;
  } sts_t;

endpackage

@@ rtl/tcw_ram.sv @@
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2560
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tcw_ctrl.sv @@
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);

  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_IDLE   = 3'd3;
  localparam logic [2:0] ST_EXEC   = 3'd4;
  localparam logic [2:0] ST_RDWAIT = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       boot_r, boot_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Sequence the item and the sweeps
  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_init = 1'b1;
        cmd.sweep_mode = SWP_RESET;
        state_nxt      = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.sweep_done = 1'b1;
        boot_nxt       = 1'b0;
        state_nxt      = boot_r ? ST_IDLE : ST_FINISH;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.kind)
          KIND_PUT_CURSOR: begin
            if (sts.scroll_need) begin
              cmd.sweep_init = 1'b1;
              cmd.sweep_mode = SWP_SCROLL;
              state_nxt      = ST_SWEEP;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
          KIND_PUT_AT: state_nxt = ST_FINISH;
          KIND_CLEAR: begin
            cmd.sweep_init = 1'b1;
            cmd.sweep_mode = SWP_CLEAR;
            state_nxt      = ST_SWEEP;
          end
          KIND_READ: state_nxt = ST_RDWAIT;
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_RDWAIT: begin
        cmd.cap_cell = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        // once the output is free, hand off the result and take the next beat in the same cycle
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/tcw_datapath.sv @@
module tcw_datapath #(
  parameter int LINE_WIDTH  = 80,
  parameter int SCREEN_ROWS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tcw_pkg::cmd_t cmd,
  output tcw_pkg::sts_t sts,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_char_code,
  input  logic [3:0]    in_background,
  input  logic [3:0]    in_foreground,
  input  logic [5:0]    in_target_row,
  input  logic [6:0]    in_target_column,
  output logic [4:0]    out_cursor_row_out,
  output logic [6:0]    out_cursor_column_out,
  output logic [15:0]   out_cell_word,
  output logic          out_scrolled
);

  import tcw_pkg::*;

  localparam int CELLS = SCREEN_ROWS * LINE_WIDTH;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int RW    = $clog2(SCREEN_ROWS + 1);
  localparam int PW    = RW + 8;

  // Registers and latched beat
  logic [5:0]      rows_in_use_r;
  logic [6:0]      tab_width_r;
  logic [1:0]      kind_r;
  logic [7:0]      char_r;
  logic [3:0]      bg_r;
  logic [3:0]      fg_r;
  logic [5:0]      trow_r;
  logic [6:0]      tcol_r;
  logic [RW-1:0]   cur_row_r;
  logic [6:0]      cur_col_r;
  logic            scrolled_r;
  logic [15:0]     cell_r;

  // Sweep unit
  logic [1:0]      mode_r;
  logic [CNTW-1:0] sweep_r;
  logic [CNTW-1:0] end_r;
  logic [CNTW-1:0] copy_end_r;
  logic            pend_r;
  logic [AW-1:0]   pend_addr_r;
  logic            pend_zero_r;

  logic [7:0]      rows_cfg8, rows8, cur8, trow8, step8, sum8;
  logic [RW-1:0]   rows, last_row, crow, trow_c, row_n, addr_row;
  logic [6:0]      tcol_c, col_n, addr_col;
  logic            is_nl, is_tab, adv_wrap, write_char;
  logic [PW-1:0]   prod, span;
  logic [AW-1:0]   exec_addr;
  logic [CNTW:0]   src;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [15:0]     ram_wdata, ram_rdata;
  logic [RW+4:0]   row_wide;

  // Clamp the rows in use to the screen
  always_comb begin
    rows_cfg8 = {2'b00, rows_in_use_r};
    if (rows_cfg8 == 8'd0) begin
      rows8 = 8'd1;
    end else if (rows_cfg8 > 8'(SCREEN_ROWS)) begin
      rows8 = 8'(SCREEN_ROWS);
    end else begin
      rows8 = rows_cfg8;
    end
    rows     = rows8[RW-1:0];
    last_row = rows - RW'(1);
  end

  // Clamp the cursor and the target position
  always_comb begin
    cur8   = 8'(cur_row_r);
    crow   = (cur8 >= rows8) ? last_row : cur_row_r;
    trow8  = {2'b00, trow_r};
    trow_c = (trow8 >= rows8) ? last_row : trow8[RW-1:0];
    tcol_c = ({1'b0, tcol_r} >= 8'(LINE_WIDTH)) ? 7'(LINE_WIDTH - 1) : tcol_r;
  end

  // Advance the cursor for a put at cursor
  always_comb begin
    is_nl      = (char_r == CHAR_NEWLINE);
    is_tab     = (char_r == CHAR_TAB);
    write_char = !is_nl && !is_tab;
    step8      = is_tab ? {1'b0, tab_width_r} : 8'd1;
    sum8       = {1'b0, cur_col_r} + step8;
    adv_wrap   = is_nl || (sum8 >= 8'(LINE_WIDTH));
    col_n      = adv_wrap ? 7'd0 : sum8[6:0];
    row_n      = adv_wrap ? crow + RW'(1) : crow;
  end

  // Form the cell address of the item
  always_comb begin
    addr_row  = (kind_r == KIND_PUT_CURSOR) ? crow : trow_c;
    addr_col  = (kind_r == KIND_PUT_CURSOR) ? cur_col_r : tcol_c;
    prod      = PW'(addr_row) * PW'(LINE_WIDTH) + PW'(addr_col);
    exec_addr = prod[AW-1:0];
    span      = PW'(rows) * PW'(LINE_WIDTH);
    src       = (CNTW + 1)'(sweep_r) + (CNTW + 1)'(LINE_WIDTH);
  end

  // Select the memory port: sweep write-back first, else the item's write
  always_comb begin
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_zero_r ? 16'd0 : ram_rdata;
    end else begin
      ram_we    = cmd.exec && (((kind_r == KIND_PUT_CURSOR) && write_char) ||
                               (kind_r == KIND_PUT_AT));
      ram_waddr = exec_addr;
      ram_wdata = {bg_r, fg_r, char_r};
    end
    ram_raddr = cmd.sweep_run ? src[AW-1:0] : exec_addr;
  end

  assign sts.kind        = kind_r;
  assign sts.scroll_need = (row_n >= rows);
  assign sts.sweep_last  = (sweep_r == end_r - CNTW'(1));

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_IN_USE_RST;
      tab_width_r   <= TAB_WIDTH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS_IN_USE) begin
        rows_in_use_r <= cfg_data[5:0];
      end else if (cfg_index == CFG_TAB_WIDTH) begin
        tab_width_r <= cfg_data;
      end
    end
  end

  // Latch the input beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      char_r <= in_char_code;
      bg_r   <= in_background;
      fg_r   <= in_foreground;
      trow_r <= in_target_row;
      tcol_r <= in_target_column;
    end
  end

  // Update the cursor and the scroll flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      scrolled_r <= 1'b0;
      mode_r     <= SWP_RESET;
    end else begin
      if (cmd.exec) begin
        scrolled_r <= 1'b0;
        if (kind_r == KIND_PUT_CURSOR) begin
          cur_row_r <= row_n;
          cur_col_r <= col_n;
        end
      end
      if (cmd.sweep_init) begin
        mode_r <= cmd.sweep_mode;
      end
      if (cmd.sweep_done) begin
        if (mode_r == SWP_SCROLL) begin
          cur_row_r  <= cur_row_r - RW'(1);
          scrolled_r <= 1'b1;
        end else if (mode_r == SWP_CLEAR) begin
          cur_row_r <= '0;
          cur_col_r <= '0;
        end
      end
    end
  end

  // Step the sweep: read the source one row down, write it back (or zero) in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      sweep_r    <= '0;
      end_r      <= (cmd.sweep_mode == SWP_RESET) ? CNTW'(CELLS) : span[CNTW-1:0];
      copy_end_r <= (cmd.sweep_mode == SWP_SCROLL) ?
                    span[CNTW-1:0] - CNTW'(LINE_WIDTH) : '0;
    end else if (cmd.sweep_run) begin
      sweep_r <= sweep_r + CNTW'(1);
    end
    pend_addr_r <= sweep_r[AW-1:0];
    pend_zero_r <= (sweep_r >= copy_end_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.sweep_run;
    end
  end

  // Capture the read cell
  always_ff @(posedge clk) begin
    if (cmd.cap_cell) begin
      cell_r <= ram_rdata;
    end
  end

  assign row_wide = (RW + 5)'(cur_row_r);

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cursor_row_out    <= row_wide[4:0];
      out_cursor_column_out <= cur_col_r;
      out_cell_word         <= (kind_r == KIND_READ) ? cell_r : 16'd0;
      out_scrolled          <= scrolled_r;
    end
  end

endmodule

@@ rtl/text_console_writer.sv @@
// Channel  Direction  Handshake              Beat contents
// in       input      in_valid / in_ready    kind, char, colors, target position
// out      output     out_valid / out_ready  cursor row and column, cell, scrolled
// cfg      input      cfg_valid / cfg_ready  register index, write data
//
// A read adds a wait state for the registered memory read before the result is loaded.
// A scroll or a clear sweeps rows * LINE_WIDTH cells, rows being rows_in_use
// held to 1..SCREEN_ROWS, one cell per cycle through the single memory write port.
// After reset all SCREEN_ROWS * LINE_WIDTH cells (2560 by default) are cleared
// before in_ready rises; cfg_ready is always high.
// A new beat is taken while the previous result waits in the output register.
module text_console_writer #(
  parameter int LINE_WIDTH  = 80,
  parameter int SCREEN_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_background,
  input  logic [3:0]  in_foreground,
  input  logic [5:0]  in_target_row,
  input  logic [6:0]  in_target_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_column_out,
  output logic [15:0] out_cell_word,
  output logic        out_scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Accept configuration beats at any time
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .LINE_WIDTH  (LINE_WIDTH),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_valid             (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_kind               (in_kind),
    .in_char_code          (in_char_code),
    .in_background         (in_background),
    .in_foreground         (in_foreground),
    .in_target_row         (in_target_row),
    .in_target_column      (in_target_column),
    .out_cursor_row_out    (out_cursor_row_out),
    .out_cursor_column_out (out_cursor_column_out),
    .out_cell_word         (out_cell_word),
    .out_scrolled          (out_scrolled)
  );

endmodule

@@ rtl/tcw_checker.sv @@
`include "assert_macros.svh"

module tcw_checker #(
  parameter int LINE_WIDTH = 80
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_cursor_column_out,
  input logic [15:0] out_cell_word,
  input logic        out_scrolled
);

  // A stalled result beat holds its column
  `TCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cursor_column_out), "stalled result beat changed")

  // The cursor column stays on the line
  `TCW_ASSERT(a_col_range, !out_valid || (out_cursor_column_out < LINE_WIDTH), "cursor column beyond line width")

  // A scroll always leaves the cursor at column 0 and reads no cell
  `TCW_ASSERT(a_scroll_home, !(out_valid && out_scrolled) || ((out_cursor_column_out == 7'd0) && (out_cell_word == 16'd0)), "scroll result with nonzero column or cell")

  // An accepted beat keeps the input closed for the next cycle
  `TCW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready right after accept")

endmodule

bind text_console_writer tcw_checker #(.LINE_WIDTH(LINE_WIDTH)) u_tcw_checker (.*);

@@ sim/tb_text_console_writer.sv @@
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int LINE_WIDTH  = 80;
  localparam int SCREEN_ROWS = 32;
  localparam int ITEM_TARGET = 1800;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [3:0] background;
    logic [3:0] foreground;
    logic [5:0] target_row;
    logic [6:0] target_column;
  } console_item_t;

  typedef struct packed {
    logic [4:0]  row_pos;
    logic [6:0]  cursor_column;
    logic [15:0] cell_word;
    logic        scrolled;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_char_code = '0;
  logic [3:0]  in_background = '0;
  logic [3:0]  in_foreground = '0;
  logic [5:0]  in_target_row = '0;
  logic [6:0]  in_target_column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_cursor_row_out;
  logic [6:0]  out_cursor_column_out;
  logic [15:0] out_cell_word;
  logic        out_scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  // Shadow copy of the screen, cursor and registers
  logic [15:0] screen_shadow [SCREEN_ROWS*LINE_WIDTH];
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned rows_reg;
  int unsigned tab_reg;

  cursor_report_t cursor_reports[$];
  int unsigned    mismatch_count = 0;
  int unsigned    send_gap_max = 14;
  int unsigned    stall_max = 14;
  int unsigned    hold_request = 0;

  text_console_writer #(
    .LINE_WIDTH (LINE_WIDTH),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_char_code         (in_char_code),
    .in_background        (in_background),
    .in_foreground        (in_foreground),
    .in_target_row        (in_target_row),
    .in_target_column     (in_target_column),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cursor_row_out   (out_cursor_row_out),
    .out_cursor_column_out(out_cursor_column_out),
    .out_cell_word        (out_cell_word),
    .out_scrolled         (out_scrolled),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned rows_active();
    if (rows_reg == 0) return 1;
    if (rows_reg > SCREEN_ROWS) return SCREEN_ROWS;
    return rows_reg;
  endfunction

  // Apply one beat to the shadow screen and return the cursor report it yields
  function automatic cursor_report_t advance_console(console_item_t beat);
    cursor_report_t rep;
    int unsigned    rows;
    int unsigned    trow;
    int unsigned    tcol;
    int unsigned    r;
    int unsigned    c;
    logic [15:0]    word;
    rows = rows_active();
    trow = (beat.target_row >= rows) ? rows - 1 : beat.target_row;
    tcol = (beat.target_column >= LINE_WIDTH) ? LINE_WIDTH - 1 : beat.target_column;
    word = {beat.background, beat.foreground, beat.char_code};
    rep = '0;
    case (beat.kind)
      KIND_PUT_CURSOR: begin
        // pull a stale cursor back inside the rows in use
        if (cur_row >= rows) cur_row = rows - 1;
        if (beat.char_code == CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          if (beat.char_code == CHAR_TAB) begin
            cur_col += tab_reg;
          end else begin
            screen_shadow[cur_row*LINE_WIDTH + cur_col] = word;
            cur_col++;
          end
          if (cur_col >= LINE_WIDTH) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // scroll up one row once the cursor falls off the bottom
        if (cur_row >= rows) begin
          for (r = 0; r + 1 < rows; r++)
            for (c = 0; c < LINE_WIDTH; c++)
              screen_shadow[r*LINE_WIDTH + c] = screen_shadow[(r+1)*LINE_WIDTH + c];
          for (c = 0; c < LINE_WIDTH; c++)
            screen_shadow[(rows-1)*LINE_WIDTH + c] = '0;
          cur_row--;
          rep.scrolled = 1'b1;
        end
      end
      KIND_PUT_AT: begin
        screen_shadow[trow*LINE_WIDTH + tcol] = word;
      end
      KIND_CLEAR: begin
        for (r = 0; r < rows*LINE_WIDTH; r++) screen_shadow[r] = '0;
        cur_row = 0;
        cur_col = 0;
      end
      KIND_READ: begin
        rep.cell_word = screen_shadow[trow*LINE_WIDTH + tcol];
      end
    endcase
    rep.row_pos       = cur_row[4:0];
    rep.cursor_column = cur_col[6:0];
    return rep;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one beat after a random gap, hold it until taken, then predict it
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] char_code,
                           input logic [3:0] background, input logic [3:0] foreground,
                           input logic [5:0] target_row, input logic [6:0] target_column);
    int unsigned   gap;
    console_item_t beat;
    gap = (send_gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, send_gap_max);
    beat = {kind, char_code, background, foreground, target_row, target_column};
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_char_code     <= char_code;
    in_background    <= background;
    in_foreground    <= foreground;
    in_target_row    <= target_row;
    in_target_column <= target_column;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cursor_reports.push_back(advance_console(beat));
  endtask

  // Drop valid and wait until every predicted report has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back, holding valid across the two beats
  task automatic set_registers(input logic [5:0] rows_value, input logic [6:0] tab_value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_data  <= {1'b0, rows_value};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rows_reg = rows_value;
    cfg_index <= CFG_TAB_WIDTH;
    cfg_data  <= tab_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tab_reg = tab_value;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item(input int unsigned newline_pct);
    int unsigned pick;
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [5:0]  row;
    logic [6:0]  col;
    pick      = $urandom_range(0, 99);
    char_code = 8'($urandom_range(0, 255));
    row       = 6'($urandom_range(0, 63));
    col       = 7'($urandom_range(0, 127));
    // at least half the targets land inside the screen without clamping
    if ($urandom_range(0, 1) == 0) begin
      row = 6'($urandom_range(0, rows_active() - 1));
      col = 7'($urandom_range(0, LINE_WIDTH - 1));
    end
    if (pick < newline_pct) begin
      kind      = KIND_PUT_CURSOR;
      char_code = CHAR_NEWLINE;
    end else if (pick < newline_pct + 8) begin
      kind      = KIND_PUT_CURSOR;
      char_code = CHAR_TAB;
    end else if (pick < 60) begin
      kind = KIND_PUT_CURSOR;
    end else if (pick < 73) begin
      kind = KIND_PUT_AT;
    end else if (pick < 98) begin
      kind = KIND_READ;
      // look back at the cell just written at the cursor
      if ($urandom_range(0, 2) == 0) begin
        row = 6'(cur_row);
        col = (cur_col == 0) ? 7'd0 : 7'(cur_col - 1);
      end
    end else begin
      kind = KIND_CLEAR;
    end
    send_beat(kind, char_code, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              row, col);
  endtask

  // Check each result beat against the oldest prediction; stall at random
  initial begin
    cursor_report_t want;
    int unsigned    stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (cursor_reports.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual row %0d col %0d cell %h",
                   $time, out_cursor_row_out, out_cursor_column_out, out_cell_word);
          mismatch_count++;
        end else begin
          want = cursor_reports.pop_front();
          compare_field("cursor_row_out", want.row_pos, out_cursor_row_out);
          compare_field("cursor_column_out", want.cursor_column, out_cursor_column_out);
          compare_field("cell_word", want.cell_word, out_cell_word);
          compare_field("scrolled", want.scrolled, out_scrolled);
        end
        stall = (stall_max == 0 || $urandom_range(0, 2) == 0) ? 0
                                                                : $urandom_range(0, stall_max);
      end
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_state();
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd63, 7'd127);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_TAB, 4'd0, 4'd0, 6'd0, 7'd0);
  endtask

  task automatic test_field_extremes();
    drain_results();
    send_beat(KIND_PUT_AT, 8'd255, 4'd15, 4'd15, 6'd0, 7'd0);
    send_beat(KIND_PUT_AT, 8'd0, 4'd15, 4'd0, 6'd63, 7'd127);
    send_beat(KIND_PUT_AT, 8'h5a, 4'd0, 4'd15, 6'd31, 7'd78);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_READ, 8'd255, 4'd15, 4'd15, 6'd31, 7'd79);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd31, 7'd78);
    send_beat(KIND_PUT_CURSOR, 8'd255, 4'd15, 4'd15, 6'd63, 7'd127);
    send_beat(KIND_PUT_CURSOR, CHAR_NEWLINE, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd0, 7'd4);
  endtask

  task automatic test_tab_and_wrap();
    drain_results();
    set_registers(6'd2, 7'd79);
    send_beat(KIND_PUT_CURSOR, 8'h78, 4'd2, 4'd7, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_TAB, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_TAB, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, 8'h79, 4'd9, 4'd1, 6'd0, 7'd0);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd0, 7'd79);
  endtask

  task automatic test_zero_tab();
    drain_results();
    set_registers(6'd3, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_TAB, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, 8'h71, 4'd4, 4'd3, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_TAB, 4'd0, 4'd0, 6'd0, 7'd0);
  endtask

  task automatic test_rows_out_of_range();
    drain_results();
    // zero rows behaves as a single row, so every newline scrolls
    set_registers(6'd0, 7'd127);
    send_beat(KIND_PUT_CURSOR, CHAR_NEWLINE, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, 8'h6b, 4'd1, 4'd14, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_TAB, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd63, 7'd0);
    drain_results();
    // rows above the screen height stop at the last screen row
    set_registers(6'd63, 7'd4);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd63, 7'd127);
    send_beat(KIND_CLEAR, 8'd0, 4'd0, 4'd0, 6'd0, 7'd0);
  endtask

  task automatic test_stale_cursor();
    drain_results();
    set_registers(6'd4, 7'd4);
    send_beat(KIND_PUT_CURSOR, CHAR_NEWLINE, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_NEWLINE, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, CHAR_NEWLINE, 4'd0, 4'd0, 6'd0, 7'd0);
    drain_results();
    // shrink the screen under the cursor without clearing
    set_registers(6'd2, 7'd4);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd0, 7'd0);
    send_beat(KIND_PUT_CURSOR, 8'h7a, 4'd6, 4'd11, 6'd0, 7'd0);
    send_beat(KIND_READ, 8'd0, 4'd0, 4'd0, 6'd1, 7'd0);
  endtask

  task automatic test_output_backpressure();
    int unsigned i;
    drain_results();
    send_gap_max = 0;
    hold_request = 400;
    for (i = 0; i < 40; i++) send_random_item(10);
    send_gap_max = 14;
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned count;
    int unsigned newline_pct;
    int unsigned i;
    logic [5:0]  rows_value;
    logic [6:0]  tab_value;
    sent = 0;
    while (sent < ITEM_TARGET) begin
      drain_results();
      newline_pct = 10;
      count       = $urandom_range(40, 120);
      case ($urandom_range(0, 15))
        0:       rows_value = 6'd0;
        1:       rows_value = 6'd32;
        2:       rows_value = 6'($urandom_range(33, 63));
        3, 4:    rows_value = 6'($urandom_range(5, 12));
        default: rows_value = 6'($urandom_range(1, 4));
      endcase
      // full-height screens need many newlines to reach a scroll
      if (rows_value >= SCREEN_ROWS) begin
        newline_pct = 40;
        count       = $urandom_range(50, 70);
      end
      case ($urandom_range(0, 7))
        0:       tab_value = 7'd0;
        1:       tab_value = 7'd79;
        2:       tab_value = 7'($urandom_range(80, 127));
        3:       tab_value = 7'd1;
        default: tab_value = 7'($urandom_range(1, 12));
      endcase
      set_registers(rows_value, tab_value);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      stall_max    = ($urandom_range(0, 3) == 0) ? 0 : 14;
      // mostly start from a clean screen; otherwise keep old rows and cursor
      if ($urandom_range(0, 3) != 0)
        send_beat(KIND_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                  7'($urandom_range(0, 127)));
      for (i = 0; i < count; i++) send_random_item(newline_pct);
      sent += count;
    end
    send_gap_max = 14;
    stall_max    = 14;
  endtask

  initial begin
    int unsigned k;
    for (k = 0; k < SCREEN_ROWS*LINE_WIDTH; k++) screen_shadow[k] = '0;
    cur_row  = 0;
    cur_col  = 0;
    rows_reg = ROWS_IN_USE_RST;
    tab_reg  = TAB_WIDTH_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_field_extremes();
    test_tab_and_wrap();
    test_zero_tab();
    test_rows_out_of_range();
    test_stale_cursor();
    test_output_backpressure();
    test_random_traffic();
    drain_results();
    // watch for stray beats long enough to cover a full-screen sweep
    repeat (3000) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

  // Bound the run well above the slowest legal schedule
  initial begin
    #250ms;
    $display("FAIL text_console_writer");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
sim/tb_text_console_writer.sv
